>>> design/ptcb_pkg.sv
// Pre-trigger capture buffer: shared sizes, widths and request codes.
// No dependencies.
`default_nettype none

package ptcb_pkg;

   // Storage sizes
   localparam int RING_DEPTH = 65536;
   localparam int POST_MAX   = 131072;
   localparam int CLIP_DEPTH = RING_DEPTH + POST_MAX;

   // Derived widths
   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam int FILL_W  = $clog2(RING_DEPTH + 1);
   localparam int POST_W  = $clog2(POST_MAX + 1);
   localparam int CLIP_AW = $clog2(CLIP_DEPTH);
   localparam int CLIP_LW = $clog2(CLIP_DEPTH + 1);

   // Port field widths
   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 18;

   localparam logic [LEN_W-1:0] POST_RESET = LEN_W'(131072);

   // Request codes
   localparam logic [MODE_W-1:0] MODE_AUDIO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

endpackage

`default_nettype wire

>>> design/pretrigger_capture_buffer.sv
// Pre-trigger capture buffer top level: history ring, clip memory and control.
// Depends on ptcb_pkg.
`default_nettype none

// Usage
//  req_*  : one request per handshake (valid/ready). mode selects audio byte,
//           trigger, or clip read; sample and read_index carry the payload.
//  rsp_*  : exactly one response per request, in request order, held in an
//           output register until taken (valid/ready).
//  csr_*  : post_length register; user writes it while the block is idle (unenforced).
// Flow
//  An audio byte, a trigger or a read goes from idle to S_RESP, which loads the
//  response register once it is free; req_ready is low until then, so no new
//  request is taken before the last one's response is loaded. The audio byte
//  that fires a pending trigger also copies the history ring into clip memory,
//  one byte a cycle through the ring's single read port (S_COPY); its response
//  is loaded in S_RESP once the copy is through.
//  While a response waits for rsp_ready the next request is still taken; it
//  then waits for the output register in turn, and req_ready stays low until
//  that request's response is loaded.
// Reset
//  Synchronous reset clears write pointer, fills, goal, recording, pending,
//  pipe valid and response valid; post_length returns to 131072. Memory is
//  not cleared: nothing reads an entry before it has been written.
module pretrigger_capture_buffer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ptcb_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [ptcb_pkg::BYTE_W-1:0]  req_sample,
   input  wire logic [ptcb_pkg::LEN_W-1:0]   req_read_index,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [ptcb_pkg::BYTE_W-1:0]  rsp_read_data,
   output logic                              rsp_index_valid,
   output logic                              rsp_recording,
   output logic                              rsp_clip_done,
   output logic      [ptcb_pkg::LEN_W-1:0]   rsp_clip_length,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic [ptcb_pkg::LEN_W-1:0]   csr_wr_data
);
   import ptcb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_RESP
   } state_type;

   // Control state
   state_type          state_ff,       state_in;
   logic [RING_AW-1:0] wp_ff,          wp_in;
   logic [FILL_W-1:0]  ring_fill_ff,   ring_fill_in;
   logic [CLIP_LW-1:0] clip_fill_ff,   clip_fill_in;
   logic [CLIP_LW-1:0] clip_goal_ff,   clip_goal_in;
   logic               recording_ff,   recording_in;
   logic               pending_ff,     pending_in;
   logic [LEN_W-1:0]   post_length_ff, post_length_in;

   // Per-request flags carried to the response stage
   logic               item_hit_ff,    item_hit_in;
   logic               item_done_ff,   item_done_in;

   // Copy sweep: read pointer, count, one-deep pipe for the read latency
   logic [RING_AW-1:0] copy_rd_ff,     copy_rd_in;
   logic [FILL_W-1:0]  copy_cnt_ff,    copy_cnt_in;
   logic               pipe_v_ff,      pipe_v_in;
   logic [CLIP_AW-1:0] pipe_k_ff,      pipe_k_in;

   // Response register
   logic               rsp_valid_ff,   rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_data_ff,    rsp_data_in;
   logic               rsp_hit_ff,     rsp_hit_in;
   logic               rsp_rec_ff,     rsp_rec_in;
   logic               rsp_done_ff,    rsp_done_in;
   logic [LEN_W-1:0]   rsp_len_ff,     rsp_len_in;

   // Memories and their ports
   logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];
   logic [BYTE_W-1:0]  clip_mem [CLIP_DEPTH];
   logic [BYTE_W-1:0]  ring_q_ff;
   logic [BYTE_W-1:0]  clip_q_ff;
   logic               ring_we, ring_re;
   logic               clip_we, clip_re;
   logic [CLIP_AW-1:0] clip_wa;
   logic [BYTE_W-1:0]  clip_wd;

   // Helpers
   logic [RING_AW-1:0] wp_next;
   logic [FILL_W-1:0]  ring_fill_next;
   logic [POST_W-1:0]  post_sat;
   logic [CLIP_LW-1:0] clip_fill_grow;
   logic               read_hit;

   assign wp_next = (wp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign ring_fill_next = (ring_fill_ff == FILL_W'(RING_DEPTH)) ?
                           ring_fill_ff : ring_fill_ff + 1'b1;
   // Post length saturates at POST_MAX when the clip starts
   assign post_sat = (32'(post_length_ff) > POST_MAX) ?
                     POST_W'(POST_MAX) : POST_W'(post_length_ff);
   assign clip_fill_grow = (clip_fill_ff < clip_goal_ff) ?
                           clip_fill_ff + 1'b1 : clip_fill_ff;
   assign read_hit = (32'(req_read_index) < 32'(clip_fill_ff));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      ring_fill_in   = ring_fill_ff;
      clip_fill_in   = clip_fill_ff;
      clip_goal_in   = clip_goal_ff;
      recording_in   = recording_ff;
      pending_in     = pending_ff;
      post_length_in = csr_wr_en ? csr_wr_data : post_length_ff;
      item_hit_in    = item_hit_ff;
      item_done_in   = item_done_ff;
      copy_rd_in     = copy_rd_ff;
      copy_cnt_in    = copy_cnt_ff;
      pipe_v_in      = pipe_v_ff;
      pipe_k_in      = pipe_k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_rec_in     = rsp_rec_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_len_in     = rsp_len_ff;
      ring_we        = 1'b0;
      ring_re        = 1'b0;
      clip_we        = 1'b0;
      clip_re        = 1'b0;
      clip_wa        = clip_fill_ff[CLIP_AW-1:0];
      clip_wd        = req_sample;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_hit_in  = 1'b0;
               item_done_in = 1'b0;
               state_in     = S_RESP;
               case (req_mode)
                  MODE_AUDIO: begin
                     if (!recording_ff) begin
                        ring_we      = 1'b1;
                        wp_in        = wp_next;
                        ring_fill_in = ring_fill_next;
                        if (pending_ff) begin
                           // oldest byte: slot 0 until the ring wraps, else write pointer
                           pending_in   = 1'b0;
                           copy_rd_in   = (ring_fill_next == FILL_W'(RING_DEPTH)) ?
                                          wp_next : '0;
                           copy_cnt_in  = '0;
                           pipe_v_in    = 1'b0;
                           clip_fill_in = CLIP_LW'(ring_fill_next);
                           clip_goal_in = CLIP_LW'(ring_fill_next) + CLIP_LW'(post_sat);
                           recording_in = 1'b1;
                           state_in     = S_COPY;
                        end
                     end else begin
                        clip_we      = (clip_fill_ff < clip_goal_ff);
                        clip_fill_in = clip_fill_grow;
                        if (clip_fill_grow >= clip_goal_ff) begin
                           recording_in = 1'b0;
                           item_done_in = 1'b1;
                        end
                     end
                  end
                  MODE_TRIGGER: begin
                     pending_in = 1'b1;
                  end
                  MODE_READ: begin
                     item_hit_in = read_hit;
                     clip_re     = read_hit;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_COPY: begin
            pipe_v_in = 1'b0;
            if (copy_cnt_ff < ring_fill_ff) begin
               ring_re     = 1'b1;
               pipe_v_in   = 1'b1;
               pipe_k_in   = CLIP_AW'(copy_cnt_ff);
               copy_cnt_in = copy_cnt_ff + 1'b1;
               copy_rd_in  = (copy_rd_ff == RING_AW'(RING_DEPTH - 1)) ?
                             '0 : copy_rd_ff + 1'b1;
            end else if (!pipe_v_ff) begin
               state_in = S_RESP;
            end
            if (pipe_v_ff) begin
               clip_we = 1'b1;
               clip_wa = pipe_k_ff;
               clip_wd = ring_q_ff;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = item_hit_ff ? clip_q_ff : '0;
               rsp_hit_in   = item_hit_ff;
               rsp_rec_in   = recording_ff;
               rsp_done_in  = item_done_ff;
               rsp_len_in   = LEN_W'(clip_fill_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wp_ff          <= '0;
         ring_fill_ff   <= '0;
         clip_fill_ff   <= '0;
         clip_goal_ff   <= '0;
         recording_ff   <= 1'b0;
         pending_ff     <= 1'b0;
         post_length_ff <= POST_RESET;
         pipe_v_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         ring_fill_ff   <= ring_fill_in;
         clip_fill_ff   <= clip_fill_in;
         clip_goal_ff   <= clip_goal_in;
         recording_ff   <= recording_in;
         pending_ff     <= pending_in;
         post_length_ff <= post_length_in;
         pipe_v_ff      <= pipe_v_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      item_hit_ff  <= item_hit_in;
      item_done_ff <= item_done_in;
      copy_rd_ff   <= copy_rd_in;
      copy_cnt_ff  <= copy_cnt_in;
      pipe_k_ff    <= pipe_k_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_len_ff   <= rsp_len_in;
   end

   // History ring: one write port (audio), one read port (copy sweep)
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= req_sample;
      end
      if (ring_re) begin
         ring_q_ff <= ring_mem[copy_rd_ff];
      end
   end

   // Clip memory: one write port (audio or copy), one read port (read requests)
   always_ff @(posedge clock) begin
      if (clip_we) begin
         clip_mem[clip_wa] <= clip_wd;
      end
      if (clip_re) begin
         clip_q_ff <= clip_mem[CLIP_AW'(req_read_index)];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_index_valid = rsp_hit_ff;
   assign rsp_recording   = rsp_rec_ff;
   assign rsp_clip_done   = rsp_done_ff;
   assign rsp_clip_length = rsp_len_ff;

endmodule

`default_nettype wire

>>> sim/pretrigger_capture_buffer_test.sv
// Self-checking testbench for pretrigger_capture_buffer: history ring, trigger, clip capture
// and clip reads, checked against an in-bench behavioural predictor. Depends on ptcb_pkg.
`default_nettype none

module pretrigger_capture_buffer_test;
   import ptcb_pkg::*;

   // Mode code the block leaves unused: status-only response, no state change
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int unsigned READ_INDEX_TOP = CLIP_DEPTH - 1;
   localparam int unsigned MAX_CYCLES     = 4_000_000;
   localparam int unsigned PHASE_REQUESTS = 200;
   localparam int unsigned SHOWN_MISMATCH = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              index_valid;
      logic              recording;
      logic              clip_done;
      logic [LEN_W-1:0]  clip_length;
   } clip_status_type;

   // DUT ports, all inputs known from time zero
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [MODE_W-1:0] req_mode       = MODE_AUDIO;
   logic [BYTE_W-1:0] req_sample     = '0;
   logic [LEN_W-1:0]  req_read_index = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [BYTE_W-1:0] rsp_read_data;
   logic              rsp_index_valid;
   logic              rsp_recording;
   logic              rsp_clip_done;
   logic [LEN_W-1:0]  rsp_clip_length;
   logic              csr_wr_en      = 1'b0;
   logic [LEN_W-1:0]  csr_wr_data    = '0;

   // Predictor's own copy of the block state
   logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
   logic [BYTE_W-1:0] clip_copy [CLIP_DEPTH];
   int unsigned       ring_wp      = 0;
   int unsigned       ring_fill    = 0;
   int unsigned       clip_fill    = 0;
   int unsigned       clip_goal    = 0;
   logic              rec_now      = 1'b0;
   logic              trig_pending = 1'b0;
   logic [LEN_W-1:0]  post_len     = POST_RESET;

   // Responses still owed by the block, oldest first
   clip_status_type due_status [$];

   // Idling controls
   logic        gaps_on       = 1'b0;
   logic        stall_on      = 1'b0;
   int unsigned burst_left    = 0;
   logic [31:0] stall_pattern = '1;
   logic [4:0]  stall_age     = '0;

   // Run bookkeeping
   int unsigned requests_sent   = 0;
   int unsigned responses_seen  = 0;
   int unsigned mismatch_count  = 0;
   int unsigned clips_completed = 0;
   int unsigned read_hits       = 0;
   int unsigned cycle_count     = 0;

   pretrigger_capture_buffer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_index_valid(rsp_index_valid),
      .rsp_recording  (rsp_recording),
      .rsp_clip_done  (rsp_clip_done),
      .rsp_clip_length(rsp_clip_length),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: rotating 32-bit ready pattern, reloaded when the 5-bit age counter
   // wraps; fully open when stalling is switched off
   always @(posedge clock) begin
      stall_age <= stall_age + 5'd1;
      if (stall_age == '0) begin
         stall_pattern <= $urandom | $urandom;
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
      end
      rsp_ready <= !stall_on || stall_pattern[0];
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_status.size());
         $display("pretrigger_capture_buffer_test failed");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [LEN_W-1:0] rand_index();
      return LEN_W'($urandom_range(0, READ_INDEX_TOP));
   endfunction

   // Works out the response to one request and moves the predictor state on.
   // A trigger only arms; the next audio byte taken while idle goes into the
   // ring first and then the whole ring is copied oldest-first into the clip.
   function automatic clip_status_type predict_capture(input logic [MODE_W-1:0] mode,
         input logic [BYTE_W-1:0] sample, input logic [LEN_W-1:0] read_index);
      clip_status_type st;
      int unsigned     post;
      int unsigned     k;
      st = '0;
      if (mode == MODE_AUDIO) begin
         if (!rec_now) begin
            ring_copy[RING_AW'(ring_wp)] = sample;
            ring_wp = (ring_wp + 1) % RING_DEPTH;
            if (ring_fill < RING_DEPTH) ring_fill++;
            if (trig_pending) begin
               trig_pending = 1'b0;
               if (ring_fill < RING_DEPTH) begin
                  // ring not yet wrapped: oldest byte sits at slot 0
                  for (k = 0; k < ring_fill; k++) begin
                     clip_copy[CLIP_AW'(k)] = ring_copy[RING_AW'(k)];
                  end
               end else begin
                  // wrapped: oldest byte sits at the write pointer
                  for (k = 0; k < RING_DEPTH; k++) begin
                     clip_copy[CLIP_AW'(k)] = ring_copy[RING_AW'((ring_wp + k) % RING_DEPTH)];
                  end
               end
               clip_fill = ring_fill;
               post = 32'(post_len);
               if (post > POST_MAX) post = POST_MAX;
               clip_goal = clip_fill + post;
               rec_now = 1'b1;
            end
         end else begin
            // recording: ring untouched, byte goes to the clip unless the goal
            // is already met (zero post length drops it)
            if (clip_fill < clip_goal && clip_fill < CLIP_DEPTH) begin
               clip_copy[CLIP_AW'(clip_fill)] = sample;
               clip_fill++;
            end
            if (clip_fill >= clip_goal) begin
               rec_now      = 1'b0;
               st.clip_done = 1'b1;
            end
         end
      end else if (mode == MODE_TRIGGER) begin
         trig_pending = 1'b1;
      end else if (mode == MODE_READ) begin
         if (read_index < clip_fill) begin
            st.read_data   = clip_copy[read_index];
            st.index_valid = 1'b1;
         end
      end
      st.recording   = rec_now;
      st.clip_length = LEN_W'(clip_fill);
      return st;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] want,
         input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCH) begin
         $display("response %0d: %s expected %0h, got %0h", responses_seen, field, want, got);
      end
   endtask

   // Response checker: every accepted response against the oldest prediction
   always @(posedge clock) begin : check_responses
      clip_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (due_status.size() == 0) begin
            flag_mismatch("unrequested response, clip_length", '0, 32'(rsp_clip_length));
         end else begin
            want = due_status.pop_front();
            if (rsp_read_data !== want.read_data)
               flag_mismatch("read_data", 32'(want.read_data), 32'(rsp_read_data));
            if (rsp_index_valid !== want.index_valid)
               flag_mismatch("index_valid", 32'(want.index_valid), 32'(rsp_index_valid));
            if (rsp_recording !== want.recording)
               flag_mismatch("recording", 32'(want.recording), 32'(rsp_recording));
            if (rsp_clip_done !== want.clip_done)
               flag_mismatch("clip_done", 32'(want.clip_done), 32'(rsp_clip_done));
            if (rsp_clip_length !== want.clip_length)
               flag_mismatch("clip_length", 32'(want.clip_length), 32'(rsp_clip_length));
            if (want.clip_done) clips_completed++;
            if (want.index_valid) read_hits++;
         end
      end
   end

   // Sends one request. Called at a rising edge; returns at the edge where the
   // request was taken, so a following request keeps valid high without a dip.
   task automatic issue_request(input logic [MODE_W-1:0] mode,
         input logic [BYTE_W-1:0] sample, input logic [LEN_W-1:0] read_index);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      due_status.push_back(predict_capture(mode, sample, read_index));
      if (mode != MODE_UNUSED) requests_sent++;
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_sample     <= sample;
      req_read_index <= read_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   // Unused payload fields carry random values so every bit gets toggled
   task automatic send_audio(input logic [BYTE_W-1:0] sample);
      issue_request(MODE_AUDIO, sample, rand_index());
   endtask

   task automatic send_trigger();
      issue_request(MODE_TRIGGER, rand_byte(), rand_index());
   endtask

   task automatic send_read(input logic [LEN_W-1:0] read_index);
      issue_request(MODE_READ, rand_byte(), read_index);
   endtask

   // Hold off until the block owes nothing
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
   endtask

   // Feeds audio until any open clip is closed
   task automatic finish_clip();
      while (rec_now) send_audio(rand_byte());
   endtask

   // Only ever called with the block idle
   task automatic write_post_length(input logic [LEN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      post_len = value;
   endtask

   // Read index biased towards the clip and its end boundary
   function automatic logic [LEN_W-1:0] pick_read_index();
      int unsigned top;
      top = (clip_fill > READ_INDEX_TOP) ? READ_INDEX_TOP : clip_fill;
      case ($urandom_range(0, 4))
         0: return rand_index();
         1: return LEN_W'(top);
         2: return LEN_W'((top == 0) ? 0 : top - 1);
         default: return LEN_W'($urandom_range(0, top));
      endcase
   endfunction

   // Zero and one post length, merged triggers, a trigger held over a
   // recording, reads on an empty clip, while recording and past the end
   task automatic test_directed_basics();
      write_post_length('0);
      send_read('0);
      send_read(LEN_W'(READ_INDEX_TOP));
      issue_request(MODE_UNUSED, rand_byte(), rand_index());
      send_audio(8'h00);
      send_audio(8'hFF);
      send_audio(8'h5A);
      send_trigger();
      send_trigger();           // merges with the first
      send_audio(8'hA5);        // fires: four history bytes become the clip
      send_read(LEN_W'(3));     // read while recording
      send_trigger();           // held until the clip closes
      send_audio(8'h11);        // dropped, closes the clip
      send_read(LEN_W'(4));     // past the clip end
      send_audio(8'h22);        // fires the held trigger
      send_read('0);
      send_audio(8'h33);
      wait_all_responses();
      write_post_length(LEN_W'(1));
      send_trigger();
      send_audio(8'h44);
      send_audio(8'h55);        // single post byte closes the clip
      send_read(LEN_W'(6));
      send_read(LEN_W'(7));
   endtask

   // Mostly well-formed captures with random content, some noise mixed in.
   // Each phase drains, sets a new post length and a new idling mix.
   task automatic test_random_captures();
      int unsigned phase;
      int unsigned post;
      int unsigned phase_start;
      for (phase = 0; phase < 8; phase++) begin
         finish_clip();
         wait_all_responses();
         case (phase)
            0: post = 3;
            1: post = 0;
            2: post = 1;
            3: post = 40;
            default: post = $urandom_range(0, 24);
         endcase
         write_post_length(LEN_W'(post));
         // phase % 4: both idling, sender gaps only, receiver stalls only, none
         gaps_on  = (phase % 4) < 2;
         stall_on = (phase % 2) == 0;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 9) < 7) begin
               repeat ($urandom_range(0, 6)) send_audio(rand_byte());
               send_trigger();
               if ($urandom_range(0, 3) == 0) send_trigger();
               do begin
                  send_audio(rand_byte());
                  if ($urandom_range(0, 3) == 0) send_read(pick_read_index());
                  if ($urandom_range(0, 15) == 0) send_trigger();
               end while (rec_now);
               repeat ($urandom_range(1, 4)) send_read(pick_read_index());
            end else begin
               issue_request(MODE_W'($urandom_range(0, 3)), rand_byte(), rand_index());
            end
         end
      end
   endtask

   // Over-range post length: saturated when the clip starts, so the clip stays
   // open across all the audio that follows; reads track it as it grows
   task automatic test_over_range_post();
      int unsigned k;
      finish_clip();
      if (trig_pending) begin
         // fire a leftover trigger under the short post length first
         send_audio(rand_byte());
         finish_clip();
      end
      wait_all_responses();
      write_post_length('1);
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      repeat (16) send_audio(rand_byte());
      send_trigger();
      send_audio(rand_byte());
      for (k = 0; k < 64; k++) begin
         send_audio(rand_byte());
         if (k % 8 == 0) send_read(pick_read_index());
      end
      send_read('0);
      send_read(LEN_W'(clip_fill - 1));
      send_read(LEN_W'(clip_fill));
      send_read(LEN_W'(READ_INDEX_TOP));
      repeat (8) send_read(rand_index());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_random_captures();
      test_over_range_post();
      wait_all_responses();
      repeat (8) @(posedge clock);
      $display("%0d requests checked, %0d clips closed, %0d reads landed inside a clip",
               requests_sent, clips_completed, read_hits);
      $display("post lengths zero to over-range, merged and held triggers, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && due_status.size() == 0) begin
         $display("pretrigger_capture_buffer_test passed");
      end else begin
         $display("pretrigger_capture_buffer_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
